FILE: rtl/core/e2q_pkg.sv
package e2q_pkg;

  // Field widths and CORDIC length
  localparam int ANGLE_WIDTH  = 16;
  localparam int QUAT_WIDTH   = 16;
  localparam int CORDIC_STEPS = 16;

  // Internal widths: CORDIC datapath, product operands, first product, Q60 sums
  localparam int CW  = 34;
  localparam int PW  = 32;
  localparam int MW  = 2 * PW;
  localparam int SW  = CW + PW;
  localparam int RS  = 62 - QUAT_WIDTH;
  localparam int ATAN_ENTRIES = 30;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [QUAT_WIDTH-1:0] QLIM = QUAT_WIDTH'(1 << (QUAT_WIDTH - 2));

  // atan(2^-i) in Q30, truncated
  localparam logic signed [CW-1:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
  };

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;
    logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  } e2q_in_t;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_i;
    logic signed [QUAT_WIDTH-1:0] quat_j;
    logic signed [QUAT_WIDTH-1:0] quat_k;
  } e2q_out_t;

endpackage

FILE: rtl/core/euler_to_quaternion.sv
// Euler ZYX angles to unit quaternion, fully pipelined.
// Throughput: one word per cycle; busy is held low, a word may start every cycle.
// Depth is set by one CORDIC iteration per stage plus range reduce, sign fix,
// two multiply stages, a sum stage and a round/saturate stage.
// Reset (rst_n, synchronous) clears only the valid pipeline; the receiver cannot stall.
module euler_to_quaternion (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  e2q_pkg::e2q_in_t    in_data,
  output logic                out_valid,
  output e2q_pkg::e2q_out_t   out_data
);
  import e2q_pkg::*;

  localparam int N = CORDIC_STEPS;

  // valid bits: cordic stages 0..N, then fix, product 1, product 2, sum, output
  logic [N:0] cv_r;
  logic       fv_r, p1v_r, p2v_r, sv_r, ov_r;

  logic signed [CW-1:0] x_r [0:N][0:2];
  logic signed [CW-1:0] y_r [0:N][0:2];
  logic signed [CW-1:0] z_r [0:N][0:2];
  logic                 neg_r [0:N][0:2];

  logic signed [CW-1:0] x_nxt [0:N][0:2];
  logic signed [CW-1:0] y_nxt [0:N][0:2];
  logic signed [CW-1:0] z_nxt [0:N][0:2];
  logic                 neg_nxt [0:2];

  // sine/cosine after sign fix: index 0 roll, 1 pitch, 2 yaw
  logic signed [PW-1:0] s_r [0:2];
  logic signed [PW-1:0] c_r [0:2];
  logic signed [CW-1:0] p_r [0:3];
  logic signed [CW-1:0] p_nxt [0:3];
  logic signed [PW-1:0] sy_r, cy_r;
  logic signed [SW-1:0] t_r [0:7];
  logic signed [SW-1:0] q_r [0:3];
  e2q_out_t             out_r;
  e2q_out_t             out_nxt;

  logic signed [ANGLE_WIDTH-1:0] ang [0:2];

  assign busy = 1'b0;
  assign ang[0] = in_data.roll_angle;
  assign ang[1] = in_data.pitch_angle;
  assign ang[2] = in_data.yaw_angle;

  // half-angle and range reduction into +-pi/2, then one CORDIC rotation per stage
  always_comb begin
    logic signed [CW-1:0] z;
    for (int a = 0; a < 3; a++) begin
      z = CW'(ang[a]) <<< (32 - ANGLE_WIDTH);
      neg_nxt[a] = 1'b0;
      if (z > HALF_PI_Q30) begin
        z = z - PI_Q30;
        neg_nxt[a] = 1'b1;
      end else if (z < -HALF_PI_Q30) begin
        z = z + PI_Q30;
        neg_nxt[a] = 1'b1;
      end
      x_nxt[0][a] = GAIN_Q30;
      y_nxt[0][a] = '0;
      z_nxt[0][a] = z;
    end
    for (int k = 1; k <= N; k++) begin
      for (int a = 0; a < 3; a++) begin
        if (z_r[k-1][a] >= 0) begin
          x_nxt[k][a] = x_r[k-1][a] - (y_r[k-1][a] >>> (k - 1));
          y_nxt[k][a] = y_r[k-1][a] + (x_r[k-1][a] >>> (k - 1));
          z_nxt[k][a] = z_r[k-1][a] - ATAN_TAB[k-1];
        end else begin
          x_nxt[k][a] = x_r[k-1][a] + (y_r[k-1][a] >>> (k - 1));
          y_nxt[k][a] = y_r[k-1][a] - (x_r[k-1][a] >>> (k - 1));
          z_nxt[k][a] = z_r[k-1][a] + ATAN_TAB[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= N; k++) begin
      for (int a = 0; a < 3; a++) begin
        x_r[k][a] <= x_nxt[k][a];
        y_r[k][a] <= y_nxt[k][a];
        z_r[k][a] <= z_nxt[k][a];
        neg_r[k][a] <= (k == 0) ? neg_nxt[a] : neg_r[(k == 0) ? 0 : k-1][a];
      end
    end
  end

  // undo range reduction sign
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      c_r[a] <= neg_r[N][a] ? PW'(-x_r[N][a]) : PW'(x_r[N][a]);
      s_r[a] <= neg_r[N][a] ? PW'(-y_r[N][a]) : PW'(y_r[N][a]);
    end
  end

  // first products, rounded to Q30: cr*cp, sr*sp, sr*cp, cr*sp
  always_comb begin
    logic signed [MW-1:0] m [0:3];
    m[0] = MW'(c_r[0]) * MW'(c_r[1]);
    m[1] = MW'(s_r[0]) * MW'(s_r[1]);
    m[2] = MW'(s_r[0]) * MW'(c_r[1]);
    m[3] = MW'(c_r[0]) * MW'(s_r[1]);
    for (int i = 0; i < 4; i++) begin
      p_nxt[i] = CW'((m[i] + (MW'(1) <<< 29)) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    p_r  <= p_nxt;
    cy_r <= c_r[2];
    sy_r <= s_r[2];
  end

  // second products against yaw terms
  always_ff @(posedge clk) begin
    t_r[0] <= SW'(p_r[0]) * SW'(cy_r);
    t_r[1] <= SW'(p_r[1]) * SW'(sy_r);
    t_r[2] <= SW'(p_r[2]) * SW'(cy_r);
    t_r[3] <= SW'(p_r[3]) * SW'(sy_r);
    t_r[4] <= SW'(p_r[3]) * SW'(cy_r);
    t_r[5] <= SW'(p_r[2]) * SW'(sy_r);
    t_r[6] <= SW'(p_r[0]) * SW'(sy_r);
    t_r[7] <= SW'(p_r[1]) * SW'(cy_r);
  end

  // Q60 sums
  always_ff @(posedge clk) begin
    q_r[0] <= t_r[0] + t_r[1];
    q_r[1] <= t_r[2] - t_r[3];
    q_r[2] <= t_r[4] + t_r[5];
    q_r[3] <= t_r[6] - t_r[7];
  end

  // round to output format and saturate
  always_comb begin
    logic signed [SW-1:0]         v;
    logic signed [QUAT_WIDTH-1:0] o [0:3];
    for (int i = 0; i < 4; i++) begin
      v = (q_r[i] + (SW'(1) <<< (RS - 1))) >>> RS;
      if (v > SW'(QLIM)) begin
        o[i] = QLIM;
      end else if (v < -SW'(QLIM)) begin
        o[i] = -QLIM;
      end else begin
        o[i] = QUAT_WIDTH'(v);
      end
    end
    out_nxt.quat_w = o[0];
    out_nxt.quat_i = o[1];
    out_nxt.quat_j = o[2];
    out_nxt.quat_k = o[3];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r  <= '0;
      fv_r  <= 1'b0;
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
      sv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      cv_r  <= {cv_r[N-1:0], start};
      fv_r  <= cv_r[N];
      p1v_r <= fv_r;
      p2v_r <= p1v_r;
      sv_r  <= p2v_r;
      ov_r  <= sv_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
